### rtl/core/dual_rail_battery_monitor_unit_assert.svh
// assertion macros shared by the battery monitor rtl
`ifndef DUAL_RAIL_BATTERY_MONITOR_UNIT_ASSERT_SVH
`define DUAL_RAIL_BATTERY_MONITOR_UNIT_ASSERT_SVH

// same-cycle implication
`define DRBM_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("drbm assertion failed");

// next-cycle implication
`define DRBM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("drbm assertion failed");

`endif

### rtl/core/drbm_pkg.sv
// shared types and constants of the dual rail battery monitor
package drbm_pkg;

	localparam int FRAC_BITS_DEF = 14;

	localparam int SAMP_W = 12;
	localparam int SUM_W  = 20;
	localparam int CNT_W  = 8;
	localparam int N_W    = CNT_W + 1;
	localparam int OFF_W  = 12;
	localparam int MV_W   = 16;
	localparam int NEG_W  = MV_W + 1;
	localparam int PCT_W  = 7;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 3;

	// avg * scale, then offset-corrected value shifted back up by the fraction bits
	localparam int PROD_W = SUM_W + MV_W;
	localparam int DIV_W  = PROD_W + 1;
	localparam int DVS_W  = MV_W + 1;
	localparam int NUM_W  = 24;
	localparam int STEP_W = $clog2(DIV_W + 1);

	localparam int QDEPTH = 2;

	localparam logic [PCT_W-1:0] PCT_FULL  = PCT_W'(100);
	localparam logic [7:0]       PCT_SCALE = 8'd200;
	localparam logic [MV_W-1:0]  MV_MAX    = '1;
	localparam logic [N_W-1:0]   N_ZERO_AS = N_W'(256);

	// register indexes
	localparam logic [IDX_W-1:0] REG_SAMPLE_COUNT = 3'd0;
	localparam logic [IDX_W-1:0] REG_SCALE        = 3'd1;
	localparam logic [IDX_W-1:0] REG_OFFSET       = 3'd2;
	localparam logic [IDX_W-1:0] REG_POS_ATT      = 3'd3;
	localparam logic [IDX_W-1:0] REG_NEG_ATT      = 3'd4;
	localparam logic [IDX_W-1:0] REG_EMPTY        = 3'd5;
	localparam logic [IDX_W-1:0] REG_FULL         = 3'd6;
	localparam logic [IDX_W-1:0] REG_ENABLE       = 3'd7;

	// reset values
	localparam logic [CNT_W-1:0] RST_COUNT  = 8'd16;
	localparam logic [MV_W-1:0]  RST_SCALE  = 16'd16384;
	localparam logic [OFF_W-1:0] RST_OFFSET = '0;
	localparam logic [MV_W-1:0]  RST_ATT    = 16'd16384;
	localparam logic [MV_W-1:0]  RST_EMPTY  = '0;
	localparam logic [MV_W-1:0]  RST_FULL   = 16'hffff;

	// one finished rail with the settings it was taken under
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [N_W-1:0]   n;
		logic             neg;
		logic [MV_W-1:0]  scale;
		logic [OFF_W-1:0] offset;
		logic [MV_W-1:0]  att;
		logic [MV_W-1:0]  empty;
		logic [MV_W-1:0]  full;
		logic             en;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} div_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### rtl/core/drbm_front.sv
// sample accumulator, rail sequencing and configuration registers
module drbm_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [drbm_pkg::IDX_W-1:0]    cfg_index,
	input  logic [drbm_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic [drbm_pkg::SAMP_W-1:0]   sample_mv,
	input  logic                          start_req,
	input  drbm_pkg::fifo_stat_t          fstat,
	output logic                          push,
	output drbm_pkg::job_t                job
);

	logic [drbm_pkg::CNT_W-1:0] count_q;
	logic [drbm_pkg::MV_W-1:0]  scale_q;
	logic [drbm_pkg::OFF_W-1:0] offset_q;
	logic [drbm_pkg::MV_W-1:0]  pos_att_q;
	logic [drbm_pkg::MV_W-1:0]  neg_att_q;
	logic [drbm_pkg::MV_W-1:0]  empty_q;
	logic [drbm_pkg::MV_W-1:0]  full_q;
	logic                       enable_q;

	logic [drbm_pkg::SUM_W-1:0] sum_q;
	logic [drbm_pkg::CNT_W-1:0] taken_q;
	logic                       neg_q;

	logic                       accept;
	logic [drbm_pkg::N_W-1:0]   n;
	logic [drbm_pkg::SUM_W-1:0] sum_eff;
	logic [drbm_pkg::SUM_W-1:0] sum_new;
	logic [drbm_pkg::CNT_W-1:0] taken_eff;
	logic                       neg_eff;
	logic                       close;

	assign sample_stall = fstat.full;
	assign accept       = sample_valid && !sample_stall;

	assign n         = (count_q == '0) ? drbm_pkg::N_ZERO_AS : {1'b0, count_q};
	assign sum_eff   = start_req ? '0 : sum_q;
	assign taken_eff = start_req ? '0 : taken_q;
	assign neg_eff   = start_req ? 1'b0 : neg_q;
	assign sum_new   = sum_eff + drbm_pkg::SUM_W'(sample_mv);
	// rail closes once the taken count, with this sample, reaches or passes the current count
	assign close     = ({1'b0, taken_eff} + drbm_pkg::N_W'(1)) >= n;

	assign push = accept && close;

	always_comb begin
		job.sum    = sum_new;
		job.n      = n;
		job.neg    = neg_eff;
		job.scale  = scale_q;
		job.offset = offset_q;
		job.att    = neg_eff ? neg_att_q : pos_att_q;
		job.empty  = empty_q;
		job.full   = full_q;
		job.en     = enable_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= drbm_pkg::RST_COUNT;
			scale_q   <= drbm_pkg::RST_SCALE;
			offset_q  <= drbm_pkg::RST_OFFSET;
			pos_att_q <= drbm_pkg::RST_ATT;
			neg_att_q <= drbm_pkg::RST_ATT;
			empty_q   <= drbm_pkg::RST_EMPTY;
			full_q    <= drbm_pkg::RST_FULL;
			enable_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				drbm_pkg::REG_SAMPLE_COUNT: count_q   <= cfg_data[drbm_pkg::CNT_W-1:0];
				drbm_pkg::REG_SCALE:        scale_q   <= cfg_data;
				drbm_pkg::REG_OFFSET:       offset_q  <= cfg_data[drbm_pkg::OFF_W-1:0];
				drbm_pkg::REG_POS_ATT:      pos_att_q <= cfg_data;
				drbm_pkg::REG_NEG_ATT:      neg_att_q <= cfg_data;
				drbm_pkg::REG_EMPTY:        empty_q   <= cfg_data;
				drbm_pkg::REG_FULL:         full_q    <= cfg_data;
				drbm_pkg::REG_ENABLE:       enable_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			taken_q <= '0;
			neg_q   <= 1'b0;
		end else if (accept) begin
			if (close) begin
				sum_q   <= '0;
				taken_q <= '0;
				neg_q   <= !neg_eff;
			end else begin
				sum_q   <= sum_new;
				taken_q <= taken_eff + drbm_pkg::CNT_W'(1);
				neg_q   <= neg_eff;
			end
		end
	end

endmodule

### rtl/core/drbm_fifo.sv
// short job queue between the accumulator and the arithmetic sequencer
`include "dual_rail_battery_monitor_unit_assert.svh"

module drbm_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  drbm_pkg::job_t       wdata,
	input  logic                 pop,
	output drbm_pkg::job_t       rdata,
	output drbm_pkg::fifo_stat_t fstat
);

	localparam int PTR_W = (drbm_pkg::QDEPTH > 1) ? $clog2(drbm_pkg::QDEPTH) : 1;
	localparam int CNT_W = $clog2(drbm_pkg::QDEPTH + 1);

	drbm_pkg::job_t   mem_q [drbm_pkg::QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	assign fstat.full  = (fill_q == CNT_W'(drbm_pkg::QDEPTH));
	assign fstat.empty = (fill_q == '0);
	assign do_push     = push && !fstat.full;
	assign do_pop      = pop && !fstat.empty;
	assign rdata       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(drbm_pkg::QDEPTH - 1)) ? '0
					: wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(drbm_pkg::QDEPTH - 1)) ? '0
					: rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

	// the accumulator must hold off while the queue is full
	`DRBM_ASSERT_IMPL(a_no_push_when_full, clk, arst_n, push, !fstat.full)

endmodule

### rtl/core/drbm_div.sv
// restoring divider, one quotient bit per cycle, dividend left aligned
`include "dual_rail_battery_monitor_unit_assert.svh"

module drbm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  drbm_pkg::div_cmd_t          cmd,
	input  logic [drbm_pkg::DIV_W-1:0]  dividend,
	input  logic [drbm_pkg::DVS_W-1:0]  divisor,
	output drbm_pkg::div_stat_t         stat,
	output logic [drbm_pkg::DIV_W-1:0]  quotient
);

	logic [drbm_pkg::DIV_W-1:0]  q_q;
	logic [drbm_pkg::DVS_W-1:0]  r_q;
	logic [drbm_pkg::DVS_W-1:0]  dvs_q;
	logic [drbm_pkg::STEP_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;

	logic [drbm_pkg::DVS_W:0]    trial;
	logic [drbm_pkg::DVS_W:0]    diff;
	logic                        ge;

	assign trial = {r_q, q_q[drbm_pkg::DIV_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = q_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			q_q   <= dividend;
			r_q   <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			q_q <= {q_q[drbm_pkg::DIV_W-2:0], ge};
			r_q <= ge ? diff[drbm_pkg::DVS_W-1:0] : trial[drbm_pkg::DVS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				cnt_q  <= cmd.steps;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - drbm_pkg::STEP_W'(1);
				if (cnt_q == drbm_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	`DRBM_ASSERT_IMPL(a_start_when_idle, clk, arst_n, cmd.start, !busy_q)

endmodule

### rtl/core/drbm_back.sv
// rail arithmetic sequencer, held positive rail and result register
`include "dual_rail_battery_monitor_unit_assert.svh"

module drbm_back #(
	parameter int FRAC_BITS = drbm_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  drbm_pkg::fifo_stat_t               fstat,
	input  drbm_pkg::job_t                     head,
	output logic                               pop,
	output drbm_pkg::div_cmd_t                 div_cmd,
	output logic [drbm_pkg::DIV_W-1:0]         div_dividend,
	output logic [drbm_pkg::DVS_W-1:0]         div_divisor,
	input  drbm_pkg::div_stat_t                div_stat,
	input  logic [drbm_pkg::DIV_W-1:0]         div_quotient,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [drbm_pkg::MV_W-1:0]          positive_mv,
	output logic signed [drbm_pkg::NEG_W-1:0]  negative_mv,
	output logic [drbm_pkg::PCT_W-1:0]         health_percent,
	output logic                               valid_res
);

	localparam int T_W = drbm_pkg::PROD_W - FRAC_BITS;
	localparam int C_W = T_W + 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AVG,
		ST_MUL,
		ST_RAIL,
		ST_DIVR,
		ST_PCT,
		ST_DIVP,
		ST_DONE
	} state_t;

	state_t                      state_q;
	drbm_pkg::job_t              job_q;
	logic [drbm_pkg::SUM_W-1:0]  avg_q;
	logic [drbm_pkg::PROD_W-1:0] prod_q;
	logic [drbm_pkg::MV_W-1:0]   mag_q;
	logic [drbm_pkg::PCT_W-1:0]  pct_q;
	logic [drbm_pkg::MV_W-1:0]   held_mv_q;
	logic [drbm_pkg::PCT_W-1:0]  held_pct_q;

	drbm_pkg::div_cmd_t          div_cmd_q;
	logic [drbm_pkg::DIV_W-1:0]  div_dividend_q;
	logic [drbm_pkg::DVS_W-1:0]  div_divisor_q;

	logic                              result_valid_q;
	logic [drbm_pkg::MV_W-1:0]         positive_mv_q;
	logic signed [drbm_pkg::NEG_W-1:0] negative_mv_q;
	logic [drbm_pkg::PCT_W-1:0]        health_q;
	logic                              valid_res_q;

	logic [T_W-1:0]              t;
	logic signed [C_W-1:0]       c;
	logic                        c_nonpos;
	logic [drbm_pkg::MV_W-1:0]   span;
	logic [drbm_pkg::MV_W-1:0]   diff;
	logic [drbm_pkg::NUM_W-1:0]  num;
	logic [drbm_pkg::PCT_W:0]    hsum;
	logic                        out_free;
	logic                        div_go;
	logic                        res_load;
	logic                        res_zero;

	assign t = prod_q[drbm_pkg::PROD_W-1:FRAC_BITS];
	assign c = $signed({2'b00, t})
		+ $signed({{(C_W - drbm_pkg::OFF_W){job_q.offset[drbm_pkg::OFF_W-1]}}, job_q.offset});
	assign c_nonpos = c[C_W-1] || (c == '0);

	assign span = job_q.full - job_q.empty;
	assign diff = mag_q - job_q.empty;
	// linear percent rounded half up: (diff * 200 + span) / (2 * span)
	assign num  = drbm_pkg::NUM_W'(diff) * drbm_pkg::NUM_W'(drbm_pkg::PCT_SCALE)
		+ drbm_pkg::NUM_W'(span);
	assign hsum = {1'b0, held_pct_q} + {1'b0, pct_q};

	assign out_free = !result_valid_q || !result_stall;
	assign pop      = (state_q == ST_IDLE) && !fstat.empty;

	// divider starts: averaging on pop, rail quotient, percent inside the linear range
	assign div_go = pop
		|| ((state_q == ST_RAIL) && !c_nonpos && (job_q.att != '0))
		|| ((state_q == ST_PCT) && (job_q.full > job_q.empty) && (mag_q > job_q.empty)
			&& (mag_q < job_q.full));
	assign res_load = (state_q == ST_DONE) && job_q.neg && out_free;
	assign res_zero = (positive_mv_q == '0) && (negative_mv_q == '0) && (health_q == '0);

	assign div_cmd      = div_cmd_q;
	assign div_dividend = div_dividend_q;
	assign div_divisor  = div_divisor_q;

	assign result_valid   = result_valid_q;
	assign positive_mv    = positive_mv_q;
	assign negative_mv    = negative_mv_q;
	assign health_percent = health_q;
	assign valid_res      = valid_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			div_cmd_q       <= '0;
			held_mv_q       <= '0;
			held_pct_q      <= '0;
			result_valid_q  <= 1'b0;
			job_q           <= '0;
			avg_q           <= '0;
			prod_q          <= '0;
			mag_q           <= '0;
			pct_q           <= '0;
			div_dividend_q  <= '0;
			div_divisor_q   <= '0;
			positive_mv_q   <= '0;
			negative_mv_q   <= '0;
			health_q        <= '0;
			valid_res_q     <= 1'b0;
		end else begin
			div_cmd_q.start <= div_go;
			if (res_load) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!fstat.empty) begin
						job_q           <= head;
						div_dividend_q  <= {head.sum, {(drbm_pkg::DIV_W - drbm_pkg::SUM_W){1'b0}}};
						div_divisor_q   <= drbm_pkg::DVS_W'(head.n);
						div_cmd_q.steps <= drbm_pkg::STEP_W'(drbm_pkg::SUM_W);
						state_q         <= ST_AVG;
					end
				end
				ST_AVG: begin
					if (div_stat.done) begin
						avg_q   <= div_quotient[drbm_pkg::SUM_W-1:0];
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= drbm_pkg::PROD_W'(avg_q) * drbm_pkg::PROD_W'(job_q.scale);
					state_q <= ST_RAIL;
				end
				ST_RAIL: begin
					if (c_nonpos) begin
						mag_q   <= '0;
						state_q <= ST_PCT;
					end else if (job_q.att == '0) begin
						mag_q   <= drbm_pkg::MV_MAX;
						state_q <= ST_PCT;
					end else begin
						div_dividend_q  <= {c[T_W:0], {FRAC_BITS{1'b0}}};
						div_divisor_q   <= drbm_pkg::DVS_W'(job_q.att);
						div_cmd_q.steps <= drbm_pkg::STEP_W'(drbm_pkg::DIV_W);
						state_q         <= ST_DIVR;
					end
				end
				ST_DIVR: begin
					if (div_stat.done) begin
						mag_q   <= (|div_quotient[drbm_pkg::DIV_W-1:drbm_pkg::MV_W]) ? drbm_pkg::MV_MAX
							: div_quotient[drbm_pkg::MV_W-1:0];
						state_q <= ST_PCT;
					end
				end
				ST_PCT: begin
					if (job_q.full <= job_q.empty || mag_q <= job_q.empty) begin
						pct_q   <= '0;
						state_q <= ST_DONE;
					end else if (mag_q >= job_q.full) begin
						pct_q   <= drbm_pkg::PCT_FULL;
						state_q <= ST_DONE;
					end else begin
						div_dividend_q  <= {num, {(drbm_pkg::DIV_W - drbm_pkg::NUM_W){1'b0}}};
						div_divisor_q   <= {span, 1'b0};
						div_cmd_q.steps <= drbm_pkg::STEP_W'(drbm_pkg::NUM_W);
						state_q         <= ST_DIVP;
					end
				end
				ST_DIVP: begin
					if (div_stat.done) begin
						pct_q   <= div_quotient[drbm_pkg::PCT_W-1:0];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!job_q.neg) begin
						held_mv_q  <= mag_q;
						held_pct_q <= pct_q;
						state_q    <= ST_IDLE;
					end else if (out_free) begin
						if (job_q.en) begin
							positive_mv_q <= held_mv_q;
							negative_mv_q <= -$signed({1'b0, mag_q});
							health_q      <= hsum[drbm_pkg::PCT_W:1];
							valid_res_q   <= 1'b1;
						end else begin
							positive_mv_q <= '0;
							negative_mv_q <= '0;
							health_q      <= '0;
							valid_res_q   <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// a new word only comes out of a finished negative rail
	`DRBM_ASSERT_IMPL(a_res_from_neg, clk, arst_n, $rose(result_valid_q), $past(res_load))
	// disabled readings carry all-zero fields
	`DRBM_ASSERT_IMPL(a_disabled_zero, clk, arst_n, result_valid_q && !valid_res_q, res_zero)
	// a popped job always kicks off the averaging division
	`DRBM_ASSERT_NEXT(a_pop_starts_div, clk, arst_n, pop, state_q == ST_AVG && div_cmd_q.start)

endmodule

### rtl/core/dual_rail_battery_monitor_unit.sv
// back end: a closed rail runs the averaging division, the multiply, the rail division and
// the percent division, plus handoff steps; the rail and percent divisions are skipped
// when their result is clamped or zero
// throughput: one sample per cycle until the two-entry rail queue fills; sustained
// rate is set by the shared bit-serial divider, which works on one closed rail at a time
// reset: arst_n clears accumulator, queue, sequencer, held rail and loads register defaults
module dual_rail_battery_monitor_unit #(
	parameter int FRAC_BITS = drbm_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [drbm_pkg::IDX_W-1:0]         cfg_index,
	input  logic [drbm_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  logic [drbm_pkg::SAMP_W-1:0]        sample_mv,
	input  logic                               start_req,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [drbm_pkg::MV_W-1:0]          positive_mv,
	output logic signed [drbm_pkg::NEG_W-1:0]  negative_mv,
	output logic [drbm_pkg::PCT_W-1:0]         health_percent,
	output logic                               valid_res
);

	drbm_pkg::fifo_stat_t       fstat;
	drbm_pkg::job_t             push_job;
	drbm_pkg::job_t             head_job;
	logic                       push;
	logic                       pop;
	drbm_pkg::div_cmd_t         div_cmd;
	drbm_pkg::div_stat_t        div_stat;
	logic [drbm_pkg::DIV_W-1:0] div_dividend;
	logic [drbm_pkg::DVS_W-1:0] div_divisor;
	logic [drbm_pkg::DIV_W-1:0] div_quotient;

	drbm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_mv    (sample_mv),
		.start_req    (start_req),
		.fstat        (fstat),
		.push         (push),
		.job          (push_job)
	);

	drbm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_job),
		.pop    (pop),
		.rdata  (head_job),
		.fstat  (fstat)
	);

	drbm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (div_cmd),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.quotient (div_quotient)
	);

	drbm_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.fstat          (fstat),
		.head           (head_job),
		.pop            (pop),
		.div_cmd        (div_cmd),
		.div_dividend   (div_dividend),
		.div_divisor    (div_divisor),
		.div_stat       (div_stat),
		.div_quotient   (div_quotient),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.positive_mv    (positive_mv),
		.negative_mv    (negative_mv),
		.health_percent (health_percent),
		.valid_res      (valid_res)
	);

endmodule

### test/tb.sv
// self-checking testbench of the dual rail battery monitor unit
`timescale 1ns / 100ps

module tb;

	localparam int FRAC_BITS     = drbm_pkg::FRAC_BITS_DEF;
	localparam int SETTLE_CYCLES = 400;
	localparam int DEAD_LIMIT    = 20000;

	localparam int SAMP_W = drbm_pkg::SAMP_W;
	localparam int SUM_W  = drbm_pkg::SUM_W;
	localparam int CNT_W  = drbm_pkg::CNT_W;
	localparam int OFF_W  = drbm_pkg::OFF_W;
	localparam int MV_W   = drbm_pkg::MV_W;
	localparam int NEG_W  = drbm_pkg::NEG_W;
	localparam int PCT_W  = drbm_pkg::PCT_W;
	localparam int CFG_W  = drbm_pkg::CFG_W;
	localparam int IDX_W  = drbm_pkg::IDX_W;

	typedef struct packed {
		logic [MV_W-1:0]         pos;
		logic signed [NEG_W-1:0] neg;
		logic [PCT_W-1:0]        health;
		logic                    valid;
	} reading_t;

	logic                    clk;
	logic                    arst_n       = 1'b0;
	logic                    cfg_we       = 1'b0;
	logic [IDX_W-1:0]        cfg_index    = '0;
	logic [CFG_W-1:0]        cfg_data     = '0;
	logic                    sample_valid = 1'b0;
	logic                    sample_stall;
	logic [SAMP_W-1:0]       sample_mv    = '0;
	logic                    start_req    = 1'b0;
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	logic [MV_W-1:0]         positive_mv;
	logic signed [NEG_W-1:0] negative_mv;
	logic [PCT_W-1:0]        health_percent;
	logic                    valid_res;

	// register copies
	logic [CNT_W-1:0]        reg_count   = drbm_pkg::RST_COUNT;
	logic [MV_W-1:0]         reg_scale   = drbm_pkg::RST_SCALE;
	logic signed [OFF_W-1:0] reg_offset  = drbm_pkg::RST_OFFSET;
	logic [MV_W-1:0]         reg_pos_att = drbm_pkg::RST_ATT;
	logic [MV_W-1:0]         reg_neg_att = drbm_pkg::RST_ATT;
	logic [MV_W-1:0]         reg_empty   = drbm_pkg::RST_EMPTY;
	logic [MV_W-1:0]         reg_full    = drbm_pkg::RST_FULL;
	logic                    reg_enable  = 1'b0;

	// accumulator copy
	logic [SUM_W-1:0] acc_sum    = '0;
	logic [CNT_W-1:0] acc_taken  = '0;
	logic             acc_on_neg = 1'b0;
	logic [MV_W-1:0]  held_mv    = '0;
	logic [PCT_W-1:0] held_pct   = '0;

	reading_t pending_readings[$];
	int       mismatches  = 0;
	int       burst_left  = 0;
	int       dead_cycles = 0;
	int       stall_left  = 0;
	int       stall_pct   = 0;
	bit       steady      = 1'b0;

	dual_rail_battery_monitor_unit #(
		.FRAC_BITS(FRAC_BITS)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.sample_mv      (sample_mv),
		.start_req      (start_req),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.positive_mv    (positive_mv),
		.negative_mv    (negative_mv),
		.health_percent (health_percent),
		.valid_res      (valid_res)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [MV_W-1:0] rail_millivolts(input logic [SUM_W-1:0] avg,
			input logic [MV_W-1:0] att);
		longint t, c, q;
		t = (longint'(avg) * longint'(reg_scale)) >>> FRAC_BITS;
		c = t + longint'(reg_offset);
		if (c <= 0)
			return '0;
		if (att == 0)
			return drbm_pkg::MV_MAX;
		q = (c << FRAC_BITS) / longint'(att);
		return (q > 65535) ? drbm_pkg::MV_MAX : MV_W'(q);
	endfunction

	function automatic logic [PCT_W-1:0] battery_percent(input logic [MV_W-1:0] mag);
		longint span, num;
		if (reg_full <= reg_empty || mag <= reg_empty)
			return '0;
		if (mag >= reg_full)
			return drbm_pkg::PCT_FULL;
		span = longint'(reg_full) - longint'(reg_empty);
		num = (longint'(mag) - longint'(reg_empty)) * 200 + span;
		return PCT_W'(num / (2 * span));
	endfunction

	// folds one accepted word into the accumulator copy, queues a reading when one closes
	function automatic void fold_sample(input logic [SAMP_W-1:0] mv, input logic first);
		int unsigned      n;
		logic [SUM_W-1:0] avg;
		logic [MV_W-1:0]  mag;
		logic [PCT_W-1:0] pct;
		int unsigned      hp;
		reading_t         r;
		n = (reg_count == 0) ? 256 : reg_count;
		if (first) begin
			acc_sum = '0;
			acc_taken = '0;
			acc_on_neg = 1'b0;
		end
		acc_sum = acc_sum + mv;
		if (acc_taken + 1 < n) begin
			acc_taken++;
			return;
		end
		avg = SUM_W'(acc_sum / n);
		acc_sum = '0;
		acc_taken = '0;
		if (!acc_on_neg) begin
			held_mv = rail_millivolts(avg, reg_pos_att);
			held_pct = battery_percent(held_mv);
			acc_on_neg = 1'b1;
			return;
		end
		acc_on_neg = 1'b0;
		mag = rail_millivolts(avg, reg_neg_att);
		pct = battery_percent(mag);
		hp = (int'(held_pct) + int'(pct)) / 2;
		r = '0;
		if (reg_enable) begin
			r.pos = held_mv;
			r.neg = '0 - {1'b0, mag};
			r.health = PCT_W'(hp);
			r.valid = 1'b1;
		end
		pending_readings.push_back(r);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			drbm_pkg::REG_SAMPLE_COUNT: reg_count = data[CNT_W-1:0];
			drbm_pkg::REG_SCALE:        reg_scale = data[MV_W-1:0];
			drbm_pkg::REG_OFFSET:       reg_offset = data[OFF_W-1:0];
			drbm_pkg::REG_POS_ATT:      reg_pos_att = data[MV_W-1:0];
			drbm_pkg::REG_NEG_ATT:      reg_neg_att = data[MV_W-1:0];
			drbm_pkg::REG_EMPTY:        reg_empty = data[MV_W-1:0];
			drbm_pkg::REG_FULL:         reg_full = data[MV_W-1:0];
			drbm_pkg::REG_ENABLE:       reg_enable = data[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_sample(input logic [SAMP_W-1:0] mv, input logic first);
		int gap;
		if (burst_left == 0) begin
			gap = steady ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
			if (gap > 0) begin
				sample_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		sample_valid <= 1'b1;
		sample_mv <= mv;
		start_req <= first;
		do @(posedge clk); while (sample_stall);
		fold_sample(mv, first);
		burst_left--;
	endtask

	// one positive and one negative word, for a sample count of one
	task automatic send_pair(input logic [SAMP_W-1:0] pos, input logic [SAMP_W-1:0] neg);
		send_sample(pos, 1'b1);
		send_sample(neg, 1'b0);
	endtask

	// sender drops valid, then everything in flight drains out
	task automatic wait_idle();
		sample_valid <= 1'b0;
		burst_left = 0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_extremes();
		write_reg(drbm_pkg::REG_SAMPLE_COUNT, 16'd1);
		write_reg(drbm_pkg::REG_ENABLE, 16'd1);
		send_pair(12'd0, 12'd0);
		send_pair(12'hfff, 12'hfff);
		send_pair(12'hfff, 12'd0);
		send_pair(12'd0, 12'hfff);
		send_pair(12'ha5a, 12'h5a5);
		wait_idle();
	endtask

	task automatic test_disabled();
		write_reg(drbm_pkg::REG_ENABLE, 16'd0);
		send_pair(12'd1234, 12'd2345);
		wait_idle();
		write_reg(drbm_pkg::REG_ENABLE, 16'hfffe);
		send_pair(12'd77, 12'd88);
		wait_idle();
		write_reg(drbm_pkg::REG_ENABLE, 16'd1);
	endtask

	task automatic test_start_request();
		// second start throws away the closed positive rail
		send_sample(12'd100, 1'b1);
		send_sample(12'd200, 1'b1);
		send_sample(12'd300, 1'b0);
		wait_idle();
		write_reg(drbm_pkg::REG_SAMPLE_COUNT, 16'd2);
		send_sample(12'd10, 1'b1);
		send_sample(12'd20, 1'b0);
		send_sample(12'd30, 1'b0);
		send_sample(12'd40, 1'b1);
		send_sample(12'd50, 1'b0);
		send_sample(12'd60, 1'b0);
		send_sample(12'd70, 1'b0);
		wait_idle();
		write_reg(drbm_pkg::REG_SAMPLE_COUNT, 16'd1);
	endtask

	task automatic test_rail_math();
		write_reg(drbm_pkg::REG_SCALE, 16'hffff);
		write_reg(drbm_pkg::REG_OFFSET, 16'h07ff);
		write_reg(drbm_pkg::REG_POS_ATT, 16'd1);
		write_reg(drbm_pkg::REG_NEG_ATT, 16'd0);
		send_pair(12'hfff, 12'd0);
		wait_idle();
		write_reg(drbm_pkg::REG_SCALE, 16'd16384);
		write_reg(drbm_pkg::REG_OFFSET, 16'hf800);
		write_reg(drbm_pkg::REG_POS_ATT, 16'd16384);
		write_reg(drbm_pkg::REG_NEG_ATT, 16'hffff);
		send_pair(12'd1000, 12'd2047);
		send_pair(12'hfff, 12'hfff);
		wait_idle();
		write_reg(drbm_pkg::REG_OFFSET, 16'd0);
		write_reg(drbm_pkg::REG_NEG_ATT, 16'd16384);
	endtask

	task automatic test_percent();
		write_reg(drbm_pkg::REG_EMPTY, 16'd1000);
		write_reg(drbm_pkg::REG_FULL, 16'd3000);
		// exactly half a percent rounds up
		send_pair(12'd1010, 12'd999);
		send_pair(12'd3000, 12'd2000);
		wait_idle();
		write_reg(drbm_pkg::REG_EMPTY, 16'd2000);
		write_reg(drbm_pkg::REG_FULL, 16'd2000);
		send_pair(12'd2500, 12'd2500);
		wait_idle();
		write_reg(drbm_pkg::REG_FULL, 16'd100);
		send_pair(12'd4000, 12'd50);
		wait_idle();
		write_reg(drbm_pkg::REG_EMPTY, 16'd0);
		write_reg(drbm_pkg::REG_FULL, 16'hffff);
	endtask

	task automatic test_count_lowered();
		write_reg(drbm_pkg::REG_SAMPLE_COUNT, 16'd255);
		send_sample(12'd4000, 1'b1);
		send_sample(12'd3000, 1'b0);
		send_sample(12'd2000, 1'b0);
		wait_idle();
		write_reg(drbm_pkg::REG_SAMPLE_COUNT, 16'd2);
		send_sample(12'd1000, 1'b0);
		send_sample(12'd500, 1'b0);
		send_sample(12'd501, 1'b0);
		wait_idle();
	endtask

	// count zero means 256 words on the positive rail, near-full words stress the sum width
	task automatic test_count_zero();
		int i;
		write_reg(drbm_pkg::REG_SAMPLE_COUNT, 16'd0);
		for (i = 0; i < 256; i++)
			send_sample(12'($urandom_range(3900, 4095)), i == 0);
		wait_idle();
		// one word closes the negative rail
		write_reg(drbm_pkg::REG_SAMPLE_COUNT, 16'd1);
		send_sample(12'($urandom_range(3900, 4095)), 1'b0);
		wait_idle();
	endtask

	function automatic logic [SAMP_W-1:0] random_mv();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return SAMP_W'($urandom_range(0, 4095));
		endcase
	endfunction

	task automatic randomize_registers();
		int             empty, full;
		logic [MV_W-1:0] v;
		v = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(13, 40)) : 16'($urandom_range(1, 6));
		write_reg(drbm_pkg::REG_SAMPLE_COUNT, v);
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = '1;
			default: v = 16'($urandom_range(12000, 24000));
		endcase
		write_reg(drbm_pkg::REG_SCALE, v);
		case ($urandom_range(0, 7))
			0: v = 16'h0800;
			1: v = 16'h07ff;
			default: v = 16'($urandom_range(0, 400) - 200);
		endcase
		write_reg(drbm_pkg::REG_OFFSET, {4'($urandom), v[OFF_W-1:0]});
		case ($urandom_range(0, 11))
			0: v = 16'd1;
			1: v = '1;
			2: v = '0;
			default: v = 16'($urandom_range(6000, 40000));
		endcase
		write_reg(drbm_pkg::REG_POS_ATT, v);
		case ($urandom_range(0, 11))
			0: v = 16'd1;
			1: v = '1;
			2: v = '0;
			default: v = 16'($urandom_range(6000, 40000));
		endcase
		write_reg(drbm_pkg::REG_NEG_ATT, v);
		empty = $urandom_range(0, 3000);
		case ($urandom_range(0, 9))
			0: full = empty;
			1: full = (empty > 0) ? $urandom_range(0, empty - 1) : 0;
			2: full = 65535;
			default: full = empty + $urandom_range(1, 4000);
		endcase
		write_reg(drbm_pkg::REG_EMPTY, 16'(empty));
		write_reg(drbm_pkg::REG_FULL, 16'(full));
		write_reg(drbm_pkg::REG_ENABLE, 16'($urandom_range(0, 5) != 0));
	endtask

	task automatic test_random_readings();
		int phase, sent, len, n, i;
		for (phase = 0; phase < 10; phase++) begin
			randomize_registers();
			steady = (phase == 3);
			n = (reg_count == 0) ? 256 : reg_count;
			sent = 0;
			while (sent < 16) begin
				len = 2 * n;
				// now and then a broken reading
				if ($urandom_range(0, 9) == 0)
					len = $urandom_range(1, 2 * n + 2);
				for (i = 0; i < len; i++) begin
					if (i == 0)
						send_sample(random_mv(), $urandom_range(0, 4) != 0);
					else
						send_sample(random_mv(), $urandom_range(0, 49) == 0);
				end
				sent += len;
			end
			wait_idle();
			steady = 1'b0;
		end
	endtask

	// receiver stall pattern: stall density is redrawn whenever its hold counter runs out
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_left <= $urandom_range(50, 300);
			case ($urandom_range(0, 3))
				0: stall_pct <= 0;
				1: stall_pct <= 25;
				2: stall_pct <= 60;
				default: stall_pct <= 90;
			endcase
		end else begin
			stall_left <= stall_left - 1;
		end
		result_stall <= !steady && ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		reading_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_readings.size() == 0) begin
				report_mismatch("result word with no reading pending");
			end else begin
				want = pending_readings.pop_front();
				if (positive_mv !== want.pos)
					report_mismatch($sformatf("positive_mv %0d, want %0d", positive_mv, want.pos));
				if (negative_mv !== want.neg)
					report_mismatch($sformatf("negative_mv %0d, want %0d", negative_mv, want.neg));
				if (health_percent !== want.health)
					report_mismatch($sformatf("health_percent %0d, want %0d",
						health_percent, want.health));
				if (valid_res !== want.valid)
					report_mismatch($sformatf("valid_res %0b, want %0b", valid_res, want.valid));
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall) || cfg_we)
			dead_cycles <= 0;
		else
			dead_cycles <= dead_cycles + 1;
	end

	initial begin
		while (dead_cycles < DEAD_LIMIT) @(posedge clk);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_extremes();
		test_disabled();
		test_start_request();
		test_rail_math();
		test_percent();
		test_count_lowered();
		test_count_zero();
		test_random_readings();
		wait_idle();
		if (mismatches == 0 && pending_readings.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
